>>> src/lchd_pkg.sv
package lchd_pkg;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_SIZE,
    PH_LEVELS,
    PH_COUNTS,
    PH_ALPHA,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_BIT,
    EX_SYM,
    EX_FLUSH
  } exec_t;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_TYPE   = 3'd1;
  localparam logic [2:0] ERR_LEVELS = 3'd2;
  localparam logic [2:0] ERR_ALPHA  = 3'd3;
  localparam logic [2:0] ERR_CODE   = 3'd4;

  localparam logic [7:0] TYPE_BYTE = 8'h02;

  localparam logic [15:0] VALUE_SAT = 16'hFFFF;
  localparam logic [16:0] BASE_SAT  = 17'h1FFFF;

  // outcome of one code bit through the step unit
  typedef struct packed {
    logic        fail;
    logic        hit;
    logic [16:0] nn;
    logic [15:0] vv;
    logic [7:0]  cl;
  } step_t;

endpackage

>>> src/lchd_ram.sv
module lchd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> src/lchd_step.sv
module lchd_step #(
  parameter int MAX_LEVELS     = 16,
  parameter int ALPHABET_DEPTH = 256
) (
  input  logic [15:0]                         code_value,
  input  logic [16:0]                         level_base,
  input  logic [7:0]                          leaves_cur,
  input  logic [7:0]                          count_cur,
  input  logic [7:0]                          count_next,
  input  logic [$clog2(ALPHABET_DEPTH+1)-1:0] leaves_before,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]     code_depth,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]     tree_levels,
  input  logic                                code_bit,
  output lchd_pkg::step_t                     res,
  output logic [$clog2(ALPHABET_DEPTH+1)-1:0] leaves_before_nxt,
  output logic [$clog2(ALPHABET_DEPTH)-1:0]   sym_index
);

  localparam int LVL_W = $clog2(MAX_LEVELS + 1);
  localparam int LB_W  = $clog2(ALPHABET_DEPTH + 1);
  localparam int AW    = $clog2(ALPHABET_DEPTH);
  localparam int SW    = ((LB_W > 8) ? LB_W : 8) + 1;

  logic [15:0]    sub_v;
  logic [16:0]    vv_full;
  logic [16:0]    sub_n;
  logic [17:0]    nn_full;
  logic [LVL_W:0] depth_inc;
  logic [SW-1:0]  lb_sum;
  logic [SW-1:0]  idx_sum;

  // node index and node count on the next level, both saturating
  always_comb begin
    sub_v   = code_value - {8'd0, leaves_cur};
    vv_full = {sub_v, code_bit};
    sub_n   = level_base - {9'd0, leaves_cur};
    nn_full = {sub_n, 1'b0};

    res.vv = vv_full[16] ? lchd_pkg::VALUE_SAT : vv_full[15:0];
    res.nn = nn_full[17] ? lchd_pkg::BASE_SAT : nn_full[16:0];

    depth_inc = {1'b0, code_depth} + (LVL_W + 1)'(1);
    res.fail  = depth_inc > {1'b0, tree_levels};

    res.cl  = (res.nn < {9'd0, count_next}) ? res.nn[7:0] : count_next;
    res.hit = res.vv < {8'd0, res.cl};

    lb_sum            = SW'(leaves_before) + SW'(count_cur);
    leaves_before_nxt = lb_sum[LB_W-1:0];
    idx_sum           = SW'(leaves_before_nxt) + SW'(res.vv[7:0]);
    sym_index         = idx_sum[AW-1:0];
  end

endmodule

>>> src/level_count_huffman_decoder_unit.sv
// Header bytes are accepted while idle; an error result is held and released through the flush state.
// Code bytes: the byte is accepted, each code bit (8 bits) goes through the shared step unit,
// each decoded symbol is read from the alphabet memory, and the final result is released when
// the byte has any; an error or the end of the file stops the byte early, and out_stall can
// hold the walk. Synchronous active-low reset clears the control state and the code walk;
// level counts and the alphabet are undefined until written.
module level_count_huffman_decoder_unit #(
  parameter int MAX_LEVELS     = 16,
  parameter int ALPHABET_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_last_of_input,
  output logic       out_last_of_file,
  output logic [2:0] out_error_code
);

  localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
  localparam int LB_W   = $clog2(ALPHABET_DEPTH + 1);
  localparam int AW     = $clog2(ALPHABET_DEPTH);
  localparam int TOT_W  = $clog2(ALPHABET_DEPTH + 256);
  localparam int CNT_AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int HI_A   = (LB_W > LVL_W) ? LB_W : LVL_W;
  localparam int HI_W   = (HI_A > 2) ? HI_A : 2;

  lchd_pkg::phase_t phase_r, phase_nxt;
  lchd_pkg::exec_t  ex_r, ex_nxt;

  logic [HI_W-1:0]  hidx_r, hidx_nxt, hidx_inc;
  logic [23:0]      osize_r, osize_nxt;
  logic [LVL_W-1:0] levels_r, levels_nxt;
  logic [TOT_W-1:0] total_r, total_nxt, total_sum;
  logic [23:0]      emitted_r, emitted_nxt, emitted_inc;

  logic [15:0]      cv_r, cv_nxt;
  logic [LVL_W-1:0] depth_r, depth_nxt;
  logic [16:0]      base_r, base_nxt;
  logic [LB_W-1:0]  lb_r, lb_nxt;
  logic [7:0]       lv_r, lv_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [2:0]       bit_idx_r, bit_idx_nxt;
  logic             sym_lof_r, sym_lof_nxt;
  logic             sym_more_r, sym_more_nxt;

  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_sym_r, pend_sym_nxt;
  logic             pend_lof_r, pend_lof_nxt;
  logic [2:0]       pend_err_r, pend_err_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_sym_r, out_sym_nxt;
  logic             out_loi_r, out_loi_nxt;
  logic             out_lof_r, out_lof_nxt;
  logic [2:0]       out_err_r, out_err_nxt;

  logic [7:0]       cnt_mem_r [MAX_LEVELS];
  logic             cnt_we;
  logic [7:0]       cnt_next;

  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic [AW-1:0]    sym_index;
  logic [LB_W-1:0]  lb_step;

  lchd_pkg::step_t  step;

  logic             in_acc;
  logic             out_free;
  logic             lof_hit;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (ex_r != lchd_pkg::EX_IDLE);

  // count of the level one below the current node
  assign cnt_next = (depth_r < LVL_W'(MAX_LEVELS)) ? cnt_mem_r[depth_r[CNT_AW-1:0]] : 8'd0;

  lchd_step #(
    .MAX_LEVELS    (MAX_LEVELS),
    .ALPHABET_DEPTH(ALPHABET_DEPTH)
  ) u_step (
    .code_value       (cv_r),
    .level_base       (base_r),
    .leaves_cur       (lv_r),
    .count_cur        (cnt_r),
    .count_next       (cnt_next),
    .leaves_before    (lb_r),
    .code_depth       (depth_r),
    .tree_levels      (levels_r),
    .code_bit         (byte_r[bit_idx_r]),
    .res              (step),
    .leaves_before_nxt(lb_step),
    .sym_index        (sym_index)
  );

  lchd_ram #(
    .WIDTH(8),
    .DEPTH(ALPHABET_DEPTH)
  ) u_alpha (
    .clk  (clk),
    .we   (ram_we),
    .waddr(hidx_r[AW-1:0]),
    .wdata(in_data_byte),
    .raddr(sym_index),
    .rdata(ram_rdata)
  );

  always_comb begin
    phase_nxt    = phase_r;
    ex_nxt       = ex_r;
    hidx_nxt     = hidx_r;
    osize_nxt    = osize_r;
    levels_nxt   = levels_r;
    total_nxt    = total_r;
    emitted_nxt  = emitted_r;
    cv_nxt       = cv_r;
    depth_nxt    = depth_r;
    base_nxt     = base_r;
    lb_nxt       = lb_r;
    lv_nxt       = lv_r;
    cnt_nxt      = cnt_r;
    byte_nxt     = byte_r;
    bit_idx_nxt  = bit_idx_r;
    sym_lof_nxt  = sym_lof_r;
    sym_more_nxt = sym_more_r;
    pend_v_nxt   = pend_v_r;
    pend_sym_nxt = pend_sym_r;
    pend_lof_nxt = pend_lof_r;
    pend_err_nxt = pend_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sym_nxt  = out_sym_r;
    out_loi_nxt  = out_loi_r;
    out_lof_nxt  = out_lof_r;
    out_err_nxt  = out_err_r;
    cnt_we       = 1'b0;
    ram_we       = 1'b0;

    hidx_inc    = hidx_r + HI_W'(1);
    total_sum   = total_r + TOT_W'(in_data_byte);
    emitted_inc = emitted_r + 24'd1;
    lof_hit     = (emitted_inc == osize_r);

    case (ex_r)
      lchd_pkg::EX_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            lchd_pkg::PH_TYPE: begin
              if (in_data_byte != lchd_pkg::TYPE_BYTE) begin
                pend_v_nxt   = 1'b1;
                pend_sym_nxt = 8'd0;
                pend_lof_nxt = 1'b0;
                pend_err_nxt = lchd_pkg::ERR_TYPE;
                phase_nxt    = lchd_pkg::PH_DONE;
                ex_nxt       = lchd_pkg::EX_FLUSH;
              end else begin
                phase_nxt = lchd_pkg::PH_SIZE;
                hidx_nxt  = '0;
              end
            end
            lchd_pkg::PH_SIZE: begin
              case (hidx_r[1:0])
                2'd0:    osize_nxt[7:0]   = in_data_byte;
                2'd1:    osize_nxt[15:8]  = in_data_byte;
                default: osize_nxt[23:16] = in_data_byte;
              endcase
              hidx_nxt = hidx_inc;
              if (hidx_r[1:0] == 2'd2) begin
                phase_nxt = lchd_pkg::PH_LEVELS;
              end
            end
            lchd_pkg::PH_LEVELS: begin
              if (in_data_byte > 8'(MAX_LEVELS)) begin
                pend_v_nxt   = 1'b1;
                pend_sym_nxt = 8'd0;
                pend_lof_nxt = 1'b0;
                pend_err_nxt = lchd_pkg::ERR_LEVELS;
                phase_nxt    = lchd_pkg::PH_DONE;
                ex_nxt       = lchd_pkg::EX_FLUSH;
              end else begin
                levels_nxt = in_data_byte[LVL_W-1:0];
                hidx_nxt   = '0;
                total_nxt  = '0;
                if (in_data_byte == 8'd0) begin
                  phase_nxt = (osize_r == 24'd0) ? lchd_pkg::PH_DONE : lchd_pkg::PH_DATA;
                end else begin
                  phase_nxt = lchd_pkg::PH_COUNTS;
                end
              end
            end
            lchd_pkg::PH_COUNTS: begin
              if (total_sum > TOT_W'(ALPHABET_DEPTH)) begin
                pend_v_nxt   = 1'b1;
                pend_sym_nxt = 8'd0;
                pend_lof_nxt = 1'b0;
                pend_err_nxt = lchd_pkg::ERR_ALPHA;
                phase_nxt    = lchd_pkg::PH_DONE;
                ex_nxt       = lchd_pkg::EX_FLUSH;
              end else begin
                cnt_we    = 1'b1;
                total_nxt = total_sum;
                hidx_nxt  = hidx_inc;
                if (16'(hidx_inc) >= 16'(levels_r)) begin
                  hidx_nxt = '0;
                  if (total_sum == '0) begin
                    phase_nxt = (osize_r == 24'd0) ? lchd_pkg::PH_DONE : lchd_pkg::PH_DATA;
                  end else begin
                    phase_nxt = lchd_pkg::PH_ALPHA;
                  end
                end
              end
            end
            lchd_pkg::PH_ALPHA: begin
              ram_we   = 1'b1;
              hidx_nxt = hidx_inc;
              if (16'(hidx_inc) >= 16'(total_r)) begin
                phase_nxt = (osize_r == 24'd0) ? lchd_pkg::PH_DONE : lchd_pkg::PH_DATA;
              end
            end
            lchd_pkg::PH_DATA: begin
              byte_nxt    = in_data_byte;
              bit_idx_nxt = 3'd7;
              ex_nxt      = lchd_pkg::EX_BIT;
            end
            default: begin
              // file complete or halted: byte is dropped
            end
          endcase
        end
      end
      lchd_pkg::EX_BIT: begin
        // a new result may displace the held one, so wait for room downstream
        if (!pend_v_r || out_free) begin
          bit_idx_nxt = bit_idx_r - 3'd1;
          if (step.fail || step.hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = pend_sym_r;
              out_loi_nxt   = 1'b0;
              out_lof_nxt   = pend_lof_r;
              out_err_nxt   = pend_err_r;
            end
          end
          if (step.fail) begin
            pend_v_nxt   = 1'b1;
            pend_sym_nxt = 8'd0;
            pend_lof_nxt = 1'b0;
            pend_err_nxt = lchd_pkg::ERR_CODE;
            phase_nxt    = lchd_pkg::PH_DONE;
            ex_nxt       = lchd_pkg::EX_FLUSH;
          end else if (step.hit) begin
            pend_v_nxt   = 1'b0;
            emitted_nxt  = emitted_inc;
            sym_lof_nxt  = lof_hit;
            sym_more_nxt = !lof_hit && (bit_idx_r != 3'd0);
            cv_nxt       = '0;
            depth_nxt    = '0;
            base_nxt     = 17'd1;
            lb_nxt       = '0;
            lv_nxt       = '0;
            cnt_nxt      = '0;
            ex_nxt       = lchd_pkg::EX_SYM;
          end else begin
            cv_nxt    = step.vv;
            depth_nxt = depth_r + LVL_W'(1);
            base_nxt  = step.nn;
            lb_nxt    = lb_step;
            lv_nxt    = step.cl;
            cnt_nxt   = cnt_next;
            if (bit_idx_r == 3'd0) begin
              ex_nxt = pend_v_r ? lchd_pkg::EX_FLUSH : lchd_pkg::EX_IDLE;
            end
          end
        end
      end
      lchd_pkg::EX_SYM: begin
        pend_v_nxt   = 1'b1;
        pend_sym_nxt = ram_rdata;
        pend_lof_nxt = sym_lof_r;
        pend_err_nxt = lchd_pkg::ERR_NONE;
        if (sym_lof_r) begin
          phase_nxt = lchd_pkg::PH_DONE;
        end
        ex_nxt = sym_more_r ? lchd_pkg::EX_BIT : lchd_pkg::EX_FLUSH;
      end
      lchd_pkg::EX_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = pend_sym_r;
          out_loi_nxt   = 1'b1;
          out_lof_nxt   = pend_lof_r;
          out_err_nxt   = pend_err_r;
          pend_v_nxt    = 1'b0;
          ex_nxt        = lchd_pkg::EX_IDLE;
        end
      end
      default: begin
        ex_nxt = lchd_pkg::EX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lchd_pkg::PH_TYPE;
      ex_r        <= lchd_pkg::EX_IDLE;
      hidx_r      <= '0;
      osize_r     <= '0;
      levels_r    <= '0;
      total_r     <= '0;
      emitted_r   <= '0;
      cv_r        <= '0;
      depth_r     <= '0;
      base_r      <= 17'd1;
      lb_r        <= '0;
      lv_r        <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ex_r        <= ex_nxt;
      hidx_r      <= hidx_nxt;
      osize_r     <= osize_nxt;
      levels_r    <= levels_nxt;
      total_r     <= total_nxt;
      emitted_r   <= emitted_nxt;
      cv_r        <= cv_nxt;
      depth_r     <= depth_nxt;
      base_r      <= base_nxt;
      lb_r        <= lb_nxt;
      lv_r        <= lv_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    bit_idx_r  <= bit_idx_nxt;
    sym_lof_r  <= sym_lof_nxt;
    sym_more_r <= sym_more_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_lof_r <= pend_lof_nxt;
    pend_err_r <= pend_err_nxt;
    out_sym_r  <= out_sym_nxt;
    out_loi_r  <= out_loi_nxt;
    out_lof_r  <= out_lof_nxt;
    out_err_r  <= out_err_nxt;
    if (cnt_we) begin
      cnt_mem_r[hidx_r[CNT_AW-1:0]] <= in_data_byte;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_symbol        = out_sym_r;
  assign out_last_of_input = out_loi_r;
  assign out_last_of_file  = out_lof_r;
  assign out_error_code    = out_err_r;

  // nothing is held back once the block is ready for a new byte
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_r == lchd_pkg::EX_IDLE) |-> !pend_v_r)
    else $error("held result left behind at byte boundary");

  // an error result always closes its transaction group
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_err_r != lchd_pkg::ERR_NONE)) |-> (out_loi_r && !out_lof_r))
    else $error("error result not marked last of input");

  // completion and halt are terminal until reset
  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lchd_pkg::PH_DONE) |=> (phase_r == lchd_pkg::PH_DONE))
    else $error("left terminal phase");

  // the alphabet read always lands in the held result
  a_sym_fills_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_r == lchd_pkg::EX_SYM) |=> pend_v_r)
    else $error("decoded symbol dropped");

endmodule
